// ----- rtl/tdew_pkg.sv -----
// Types and codes shared by the thread delay and event wait table.
package tdew_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_EVENT     = 3'd1;
    localparam logic [2:0] OP_START     = 3'd2;
    localparam logic [2:0] OP_ADD_DELAY = 3'd3;
    localparam logic [2:0] OP_SET_WAIT  = 3'd4;
    localparam logic [2:0] OP_END       = 3'd5;
    localparam logic [2:0] OP_STOP_ID   = 3'd6;
    localparam logic [2:0] OP_STOP_ALL  = 3'd7;

    localparam logic [1:0] REL_EQ = 2'd0;
    localparam logic [1:0] REL_LT = 2'd1;
    localparam logic [1:0] REL_GT = 2'd2;
    localparam logic [1:0] REL_NE = 2'd3;

    localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         slot;
        logic signed [31:0] amount;
        logic [7:0]         event_code;
        logic [1:0]         relation;
        logic signed [31:0] thread_id;
        logic               exclude_self;
    } t_in_item;

    typedef struct packed {
        logic [7:0] run_mask;
        logic [7:0] woken_mask;
        logic [2:0] start_slot;
        logic       ok;
        logic [3:0] active_count;
    } t_out_item;

    typedef struct packed {
        logic               active;
        logic signed [31:0] id;
        logic signed [31:0] delay;
        logic [7:0]         wait_event;
        logic [1:0]         wait_relation;
        logic signed [31:0] wait_argument;
    } t_slot_rec;

endpackage

// ----- rtl/thread_delay_event_wait_table_unit.sv -----
// Thread slot table: per-slot delays and event waits swept through one slot memory.
// Every item sweeps all slots: a read per cycle, modify and write back in the cycle after.
// The sweep reads the slots in turn through the single read port of the slot memory;
// one item at a time: no new item is accepted until the sweep of the last one is done.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) clears control state and the per-slot written bits,
// so every slot reads as all zero until written; no clearing pass is needed.
module thread_delay_event_wait_table_unit #(
    parameter int SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tdew_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tdew_pkg::t_out_item o_out_item
);
    import tdew_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (IW > 3) ? IW : 3;
    localparam logic [3:0] FULL_CNT = 4'((SLOTS > 15) ? 15 : SLOTS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_HOLD  = 3'b100
    } t_state;

    t_state     r_state;
    t_in_item   r_item;
    logic [CW-1:0] r_rd_cnt;
    logic       r_pv;
    logic [IW-1:0] r_pidx;
    t_slot_rec  r_mem [SLOTS];
    t_slot_rec  r_rdata;
    logic       r_rdata_ok;
    logic [SLOTS-1:0] r_written;
    logic [7:0] r_run;
    logic [7:0] r_woken;
    logic [2:0] r_sslot;
    logic       r_found;
    logic [3:0] r_cnt;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       rd_en;
    logic [IW-1:0] rd_idx;
    logic       sweep_done;
    logic       finish;
    logic       out_free;
    logic       in_accept;

    t_slot_rec  cur;
    t_slot_rec  n_rec;
    logic [7:0] n_run;
    logic [7:0] n_woken;
    logic [2:0] n_sslot;
    logic       n_found;
    logic [3:0] n_cnt;
    logic       hit;
    logic       holds;
    logic signed [33:0] diff;
    logic signed [32:0] sum;
    logic signed [31:0] tick_delay;
    logic signed [31:0] add_delay;
    t_out_item  result;

    assign rd_en      = (r_state == S_SWEEP) && (r_rd_cnt < CW'(SLOTS));
    assign rd_idx     = r_rd_cnt[IW-1:0];
    assign sweep_done = (r_state == S_SWEEP) && !rd_en && !r_pv;
    assign finish     = sweep_done || (r_state == S_HOLD);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_accept  = i_in_valid && (r_state == S_IDLE);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Slot update for the entry whose read data has just arrived
    always_comb begin
        cur = r_rdata_ok ? r_rdata : '0;
        hit = MW'(r_item.slot) == MW'(r_pidx);

        diff = 34'(cur.delay) - 34'(r_item.amount);
        if (diff[33]) begin
            tick_delay = '0;
        end else if (diff > 34'sd2147483647) begin
            tick_delay = I32_MAX;
        end else begin
            tick_delay = diff[31:0];
        end

        sum = 33'(cur.delay) + 33'(r_item.amount);
        if (sum[32] != sum[31]) begin
            add_delay = sum[32] ? I32_MIN : I32_MAX;
        end else begin
            add_delay = sum[31:0];
        end

        case (cur.wait_relation)
            REL_EQ:  holds = (r_item.amount == cur.wait_argument);
            REL_LT:  holds = (r_item.amount <  cur.wait_argument);
            REL_GT:  holds = (r_item.amount >  cur.wait_argument);
            default: holds = (r_item.amount != cur.wait_argument);
        endcase

        n_rec   = cur;
        n_run   = r_run;
        n_woken = r_woken;
        n_sslot = r_sslot;
        n_found = r_found;

        unique case (r_item.operation)
            OP_TICK: begin
                if (cur.wait_event == '0) begin
                    if (cur.delay > 32'sd0) begin
                        n_rec.delay = tick_delay;
                    end else if (cur.active) begin
                        n_run = r_run | (8'd1 << r_pidx);
                    end
                end
            end
            OP_EVENT: begin
                if (r_item.event_code != '0 && cur.wait_event == r_item.event_code
                        && holds) begin
                    n_rec.wait_event    = '0;
                    n_rec.wait_argument = '0;
                    n_woken = r_woken | (8'd1 << r_pidx);
                end
            end
            OP_START: begin
                // take only the lowest free slot
                if (!r_found && !cur.active) begin
                    n_rec.active        = 1'b1;
                    n_rec.id            = r_item.thread_id;
                    n_rec.delay         = '0;
                    n_rec.wait_event    = '0;
                    n_rec.wait_relation = '0;
                    n_rec.wait_argument = '0;
                    n_sslot = 3'(r_pidx);
                    n_found = 1'b1;
                end
            end
            OP_ADD_DELAY: begin
                if (hit) begin
                    n_rec.delay = add_delay;
                end
            end
            OP_SET_WAIT: begin
                if (hit) begin
                    n_rec.wait_event    = r_item.event_code;
                    n_rec.wait_relation = r_item.relation;
                    n_rec.wait_argument = r_item.amount;
                end
            end
            OP_END: begin
                if (hit) begin
                    n_rec.active = 1'b0;
                end
            end
            OP_STOP_ID: begin
                if (!(r_item.exclude_self && hit) && cur.id == r_item.thread_id) begin
                    n_rec.active = 1'b0;
                    n_rec.id     = '0;
                    n_rec.delay  = '0;
                end
            end
            default: begin
                n_rec.active = 1'b0;
                n_rec.id     = '0;
                n_rec.delay  = '0;
            end
        endcase

        n_cnt = (r_cnt == 4'd15) ? r_cnt : r_cnt + 4'(n_rec.active);

        result.run_mask     = r_run;
        result.woken_mask   = r_woken;
        result.start_slot   = r_sslot;
        result.ok           = (r_item.operation != OP_START) || r_found;
        result.active_count = r_cnt;
    end

    // Slot memory: read one entry, write back the previous one
    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_mem[r_pidx] <= n_rec;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rdata_ok <= 1'b0;
        end else begin
            if (r_pv) begin
                r_written[r_pidx] <= 1'b1;
            end
            if (rd_en) begin
                r_rdata_ok <= r_written[rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        if (rd_en) begin
            r_pidx <= rd_idx;
        end
        if (in_accept) begin
            r_run   <= '0;
            r_woken <= '0;
            r_sslot <= '0;
            r_cnt   <= '0;
        end else if (r_pv) begin
            r_run   <= n_run;
            r_woken <= n_woken;
            r_sslot <= n_sslot;
            r_cnt   <= n_cnt;
        end
        if (finish && out_free) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_cnt    <= '0;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= rd_en;
            if (in_accept) begin
                r_found <= 1'b0;
            end else if (r_pv) begin
                r_found <= n_found;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_rd_cnt <= '0;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (rd_en) begin
                        r_rd_cnt <= r_rd_cnt + CW'(1);
                    end
                    if (sweep_done) begin
                        r_state <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // load the result when the output is free, else drop a taken item
            if (finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && rd_en) |-> (r_pidx != rd_idx))
        else $error("slot read and write back collide on one entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SWEEP) && (r_rd_cnt == '0) && !r_pv)
        else $error("sweep did not start cleanly after accept");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.ok) |-> (o_out_item.active_count == FULL_CNT))
        else $error("start failed while a slot was free");
`endif

endmodule
